@@ hw/rtl/query_text_tokenizer_core_assert.svh @@
// Assertion macros shared by the tokenizer checker
`ifndef QUERY_TEXT_TOKENIZER_CORE_ASSERT_SVH
`define QUERY_TEXT_TOKENIZER_CORE_ASSERT_SVH

// same-cycle implication
`define QTT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("query_text_tokenizer_core assertion failed");

// next-cycle implication
`define QTT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("query_text_tokenizer_core assertion failed");

`endif

@@ hw/rtl/qtt_pkg.sv @@
// Types and constants of the query text tokenizer
package qtt_pkg;

   localparam int TEXT_LEN_MAX_DEF  = 4095;
   localparam int POSITION_BITS_DEF = 16;

   localparam int POS_W      = 16;
   localparam int SLIMIT_W   = 12;
   localparam int ILIMIT_W   = 8;
   localparam int NLIMIT_W   = 6;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] EV_TEXT  = 2'd0;
   localparam logic [1:0] EV_DONE  = 2'd1;
   localparam logic [1:0] EV_ERROR = 2'd2;

   localparam logic [3:0] KIND_EOF     = 4'd0;
   localparam logic [3:0] KIND_LBRACE  = 4'd1;
   localparam logic [3:0] KIND_RBRACE  = 4'd2;
   localparam logic [3:0] KIND_LPAREN  = 4'd3;
   localparam logic [3:0] KIND_RPAREN  = 4'd4;
   localparam logic [3:0] KIND_COLON   = 4'd5;
   localparam logic [3:0] KIND_COMMA   = 4'd6;
   localparam logic [3:0] KIND_STRING  = 4'd7;
   localparam logic [3:0] KIND_IDENT   = 4'd8;
   localparam logic [3:0] KIND_NUMBER  = 4'd9;
   localparam logic [3:0] KIND_INVALID = 4'd10;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_UNTERM     = 3'd1;
   localparam logic [2:0] ERR_STR_LONG   = 3'd2;
   localparam logic [2:0] ERR_ESCAPE     = 3'd3;
   localparam logic [2:0] ERR_IDENT_LONG = 3'd4;
   localparam logic [2:0] ERR_NUM_LONG   = 3'd5;
   localparam logic [2:0] ERR_UNEXPECTED = 3'd6;

   localparam logic [1:0] REG_STRING_LIMIT = 2'd0;
   localparam logic [1:0] REG_IDENT_LIMIT  = 2'd1;
   localparam logic [1:0] REG_NUMBER_LIMIT = 2'd2;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2c;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_DOT    = 8'h2e;
   localparam logic [7:0] CH_COLON  = 8'h3a;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_UNDER  = 8'h5f;
   localparam logic [7:0] CH_LOW_N  = 8'h6e;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LBRACE = 8'h7b;
   localparam logic [7:0] CH_RBRACE = 8'h7d;

   typedef struct packed {
      logic [1:0]       event_res;
      logic [3:0]       token_kind;
      logic [7:0]       text_byte;
      logic [POS_W-1:0] token_line;
      logic [POS_W-1:0] token_col;
      logic [2:0]       error_code;
      logic             last_in_run;
   } rsp_type;

endpackage

@@ hw/rtl/qtt_stream_if.sv @@
// Request and response stream interfaces of the tokenizer
interface qtt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;

   modport source (output valid, output source_byte, input ready);
   modport sink (input valid, input source_byte, output ready);
endinterface

interface qtt_rsp_if
   import qtt_pkg::*;
;
   logic             valid;
   logic             ready;
   logic [1:0]       event_res;
   logic [3:0]       token_kind;
   logic [7:0]       text_byte;
   logic [POS_W-1:0] token_line;
   logic [POS_W-1:0] token_col;
   logic [2:0]       error_code;
   logic             last_in_run;

   modport source (output valid, output event_res, output token_kind, output text_byte,
                   output token_line, output token_col, output error_code,
                   output last_in_run, input ready);
   modport sink (input valid, input event_res, input token_kind, input text_byte,
                 input token_line, input token_col, input error_code,
                 input last_in_run, output ready);
endinterface

@@ hw/rtl/query_text_tokenizer_core.sv @@
// Streaming lexical tokenizer: one source byte per beat, up to two result beats
//
//   channel  dir  handshake           payload
//   req      in   valid/ready         source_byte
//   rsp      out  valid/ready         event_res token_kind text_byte token_line
//                                     token_col error_code last_in_run
//   csr      in   APB psel/penable    string/ident/number limits
//
// One source byte is taken per cycle while req.ready is high; the lexer state updates in that cycle.
// A byte giving two results needs two rsp beats; the 4-entry result queue drains one
// beat per cycle while rsp.ready is high.
// req.ready is low while the queue has fewer than two free entries.
// reset is synchronous; no clearing pass is needed.
module query_text_tokenizer_core
   import qtt_pkg::*;
#(
   parameter int TEXT_LEN_MAX  = TEXT_LEN_MAX_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   qtt_req_if.sink               req,
   qtt_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int PW    = POSITION_BITS;
   localparam int LEN_W = $clog2(TEXT_LEN_MAX + 1);
   localparam int CMP_W = (LEN_W > SLIMIT_W) ? LEN_W : SLIMIT_W;

   localparam logic [PW-1:0] POS_MAX = '1;
   localparam logic [PW-1:0] POS_ONE = PW'(1);

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_COMMENT = 3'd1;
   localparam logic [2:0] MODE_STRING  = 3'd2;
   localparam logic [2:0] MODE_ESCAPE  = 3'd3;
   localparam logic [2:0] MODE_IDENT   = 3'd4;
   localparam logic [2:0] MODE_NUMBER  = 3'd5;
   localparam logic [2:0] MODE_MINUS   = 3'd6;
   localparam logic [2:0] MODE_ERROR   = 3'd7;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;

   function automatic logic [CMP_W-1:0] cap_limit(input logic [CMP_W-1:0] v);
      return (v > CMP_W'(TEXT_LEN_MAX)) ? CMP_W'(TEXT_LEN_MAX) : v;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
   endfunction

   function automatic logic [PW-1:0] adv_line(input logic [PW-1:0] line,
                                              input logic [7:0] c);
      if (c == CH_LF && line != POS_MAX) begin
         return line + POS_ONE;
      end
      return line;
   endfunction

   function automatic logic [PW-1:0] adv_col(input logic [PW-1:0] col, input logic [7:0] c);
      if (c == CH_LF) begin
         return POS_ONE;
      end
      if (col != POS_MAX) begin
         return col + POS_ONE;
      end
      return col;
   endfunction

   function automatic rsp_type mk(input logic [1:0] ev, input logic [3:0] kind,
                                  input logic [7:0] b, input logic [PW-1:0] line,
                                  input logic [PW-1:0] col, input logic [2:0] err);
      rsp_type r;
      r.event_res   = ev;
      r.token_kind  = kind;
      r.text_byte   = b;
      r.token_line  = POS_W'(line);
      r.token_col   = POS_W'(col);
      r.error_code  = err;
      r.last_in_run = 1'b0;
      return r;
   endfunction

   // config registers
   logic [SLIMIT_W-1:0] slimit_ff;
   logic [ILIMIT_W-1:0] ilimit_ff;
   logic [NLIMIT_W-1:0] nlimit_ff;
   logic [1:0]          csr_idx;
   logic                csr_wr;

   // lexer state
   logic [2:0]       mode_ff, mode_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [PW-1:0]    line_ff, line_in;
   logic [PW-1:0]    col_ff, col_in;
   logic [PW-1:0]    sline_ff, sline_in;
   logic [PW-1:0]    scol_ff, scol_in;

   // result queue
   rsp_type           q_ff [QDEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;

   logic [CMP_W-1:0] scap, icap, ncap;
   logic [CMP_W-1:0] len_ext;
   rsp_type          res [2];
   logic [1:0]       nres;
   logic             accept;
   logic             pop;
   logic [7:0]       c;

   assign c       = req.source_byte;
   assign accept  = req.valid && req.ready;
   assign pop     = rsp.valid && rsp.ready;
   assign scap    = cap_limit(CMP_W'(slimit_ff));
   assign icap    = cap_limit(CMP_W'(ilimit_ff));
   assign ncap    = cap_limit(CMP_W'(nlimit_ff));
   assign len_ext = CMP_W'(len_ff);

   always_comb begin
      logic [2:0]       mode_v;
      logic [LEN_W-1:0] len_v;
      logic [PW-1:0]    line_v, col_v, sl_v, sc_v;
      logic [1:0]       n_v;
      logic             go_idle;
      logic             flt;
      logic [2:0]       flt_code;
      logic [PW-1:0]    flt_line, flt_col;
      logic [7:0]       d_v;
      logic [3:0]       punct;
      rsp_type          r_v [2];

      mode_v   = mode_ff;
      len_v    = len_ff;
      line_v   = line_ff;
      col_v    = col_ff;
      sl_v     = sline_ff;
      sc_v     = scol_ff;
      n_v      = 2'd0;
      go_idle  = 1'b0;
      flt      = 1'b0;
      flt_code = ERR_NONE;
      flt_line = line_ff;
      flt_col  = col_ff;
      d_v      = CH_NUL;
      punct    = KIND_EOF;
      r_v[0]   = mk(EV_TEXT, KIND_EOF, CH_NUL, POS_ONE, POS_ONE, ERR_NONE);
      r_v[1]   = r_v[0];

      case (mode_ff)
         MODE_COMMENT: begin
            if (c == CH_NUL || c == CH_LF) begin
               go_idle = 1'b1;
            end else begin
               line_v = adv_line(line_v, c);
               col_v  = adv_col(col_v, c);
            end
         end
         MODE_STRING: begin
            if (c == CH_NUL) begin
               flt      = 1'b1;
               flt_code = ERR_UNTERM;
            end else if (c == CH_QUOTE) begin
               r_v[n_v[0]] = mk(EV_DONE, KIND_STRING, CH_NUL, sl_v, sc_v, ERR_NONE);
               n_v         = n_v + 2'd1;
               line_v      = adv_line(line_v, c);
               col_v       = adv_col(col_v, c);
               mode_v      = MODE_IDLE;
               len_v       = '0;
            end else if (len_ext >= scap) begin
               flt      = 1'b1;
               flt_code = ERR_STR_LONG;
            end else begin
               if (c == CH_BSLASH) begin
                  mode_v = MODE_ESCAPE;
               end else begin
                  len_v       = len_v + LEN_W'(1);
                  r_v[n_v[0]] = mk(EV_TEXT, KIND_STRING, c, sl_v, sc_v, ERR_NONE);
                  n_v         = n_v + 2'd1;
               end
               line_v = adv_line(line_v, c);
               col_v  = adv_col(col_v, c);
            end
         end
         MODE_ESCAPE: begin
            case (c)
               CH_QUOTE:  d_v = CH_QUOTE;
               CH_BSLASH: d_v = CH_BSLASH;
               CH_LOW_N:  d_v = CH_LF;
               CH_LOW_T:  d_v = CH_TAB;
               default:   d_v = CH_NUL;
            endcase
            if (d_v == CH_NUL) begin
               if (c != CH_NUL) begin
                  line_v = adv_line(line_v, c);
                  col_v  = adv_col(col_v, c);
               end
               flt      = 1'b1;
               flt_code = ERR_ESCAPE;
               flt_line = line_v;
               flt_col  = col_v;
            end else begin
               len_v       = len_v + LEN_W'(1);
               r_v[n_v[0]] = mk(EV_TEXT, KIND_STRING, d_v, sl_v, sc_v, ERR_NONE);
               n_v         = n_v + 2'd1;
               line_v      = adv_line(line_v, c);
               col_v       = adv_col(col_v, c);
               mode_v      = MODE_STRING;
            end
         end
         MODE_IDENT, MODE_NUMBER: begin
            if ((mode_ff == MODE_IDENT && (is_alpha(c) || is_digit(c) || c == CH_UNDER)) ||
                (mode_ff == MODE_NUMBER && (is_digit(c) || c == CH_DOT || c == CH_MINUS))) begin
               if (len_ext >= ((mode_ff == MODE_IDENT) ? icap : ncap)) begin
                  flt      = 1'b1;
                  flt_code = (mode_ff == MODE_IDENT) ? ERR_IDENT_LONG : ERR_NUM_LONG;
               end else begin
                  len_v       = len_v + LEN_W'(1);
                  r_v[n_v[0]] = mk(EV_TEXT, (mode_ff == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER,
                                   c, sl_v, sc_v, ERR_NONE);
                  n_v         = n_v + 2'd1;
                  line_v      = adv_line(line_v, c);
                  col_v       = adv_col(col_v, c);
               end
            end else begin
               r_v[n_v[0]] = mk(EV_DONE, (mode_ff == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER,
                                CH_NUL, sl_v, sc_v, ERR_NONE);
               n_v         = n_v + 2'd1;
               go_idle     = 1'b1;
            end
         end
         MODE_MINUS: begin
            if (!is_digit(c)) begin
               flt      = 1'b1;
               flt_code = ERR_UNEXPECTED;
               flt_line = sl_v;
               flt_col  = sc_v;
            end else if (ncap == '0) begin
               len_v    = '0;
               flt      = 1'b1;
               flt_code = ERR_NUM_LONG;
               flt_line = sl_v;
               flt_col  = sc_v;
            end else begin
               len_v       = LEN_W'(1);
               r_v[n_v[0]] = mk(EV_TEXT, KIND_NUMBER, CH_MINUS, sl_v, sc_v, ERR_NONE);
               n_v         = n_v + 2'd1;
               if (ncap == CMP_W'(1)) begin
                  flt      = 1'b1;
                  flt_code = ERR_NUM_LONG;
               end else begin
                  len_v       = LEN_W'(2);
                  r_v[n_v[0]] = mk(EV_TEXT, KIND_NUMBER, c, sl_v, sc_v, ERR_NONE);
                  n_v         = n_v + 2'd1;
                  line_v      = adv_line(line_v, c);
                  col_v       = adv_col(col_v, c);
                  mode_v      = MODE_NUMBER;
               end
            end
         end
         MODE_ERROR: begin
            if (c == CH_NUL) begin
               mode_v = MODE_IDLE;
               len_v  = '0;
               line_v = POS_ONE;
               col_v  = POS_ONE;
               sl_v   = POS_ONE;
               sc_v   = POS_ONE;
            end
         end
         default: begin
            go_idle = 1'b1;
         end
      endcase

      if (go_idle) begin
         mode_v = MODE_IDLE;
         len_v  = '0;
         case (c)
            CH_LBRACE: punct = KIND_LBRACE;
            CH_RBRACE: punct = KIND_RBRACE;
            CH_LPAREN: punct = KIND_LPAREN;
            CH_RPAREN: punct = KIND_RPAREN;
            CH_COLON:  punct = KIND_COLON;
            CH_COMMA:  punct = KIND_COMMA;
            default:   punct = KIND_EOF;
         endcase
         if (c == CH_NUL) begin
            r_v[n_v[0]] = mk(EV_DONE, KIND_EOF, CH_NUL, line_v, col_v, ERR_NONE);
            n_v         = n_v + 2'd1;
            line_v      = POS_ONE;
            col_v       = POS_ONE;
            sl_v        = POS_ONE;
            sc_v        = POS_ONE;
         end else if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR}) begin
            line_v = adv_line(line_v, c);
            col_v  = adv_col(col_v, c);
         end else if (c == CH_HASH) begin
            mode_v = MODE_COMMENT;
            line_v = adv_line(line_v, c);
            col_v  = adv_col(col_v, c);
         end else if (punct != KIND_EOF) begin
            r_v[n_v[0]] = mk(EV_DONE, punct, CH_NUL, line_v, col_v, ERR_NONE);
            n_v         = n_v + 2'd1;
            line_v      = adv_line(line_v, c);
            col_v       = adv_col(col_v, c);
         end else begin
            sl_v     = line_v;
            sc_v     = col_v;
            flt_line = line_v;
            flt_col  = col_v;
            if (c == CH_QUOTE) begin
               mode_v = MODE_STRING;
               line_v = adv_line(line_v, c);
               col_v  = adv_col(col_v, c);
            end else if (c == CH_MINUS) begin
               mode_v = MODE_MINUS;
               line_v = adv_line(line_v, c);
               col_v  = adv_col(col_v, c);
            end else if (is_alpha(c) || c == CH_UNDER || is_digit(c)) begin
               if ((is_digit(c) ? ncap : icap) == '0) begin
                  flt      = 1'b1;
                  flt_code = is_digit(c) ? ERR_NUM_LONG : ERR_IDENT_LONG;
               end else begin
                  mode_v      = is_digit(c) ? MODE_NUMBER : MODE_IDENT;
                  len_v       = LEN_W'(1);
                  r_v[n_v[0]] = mk(EV_TEXT, is_digit(c) ? KIND_NUMBER : KIND_IDENT,
                                   c, sl_v, sc_v, ERR_NONE);
                  n_v         = n_v + 2'd1;
                  line_v      = adv_line(line_v, c);
                  col_v       = adv_col(col_v, c);
               end
            end else begin
               flt      = 1'b1;
               flt_code = ERR_UNEXPECTED;
            end
         end
      end

      if (flt) begin
         r_v[n_v[0]] = mk(EV_ERROR, KIND_INVALID, CH_NUL, flt_line, flt_col, flt_code);
         n_v         = n_v + 2'd1;
         len_v       = '0;
         if (c == CH_NUL) begin
            mode_v = MODE_IDLE;
            line_v = POS_ONE;
            col_v  = POS_ONE;
            sl_v   = POS_ONE;
            sc_v   = POS_ONE;
         end else begin
            mode_v = MODE_ERROR;
         end
      end

      if (n_v == 2'd1) begin
         r_v[0].last_in_run = 1'b1;
      end else if (n_v == 2'd2) begin
         r_v[1].last_in_run = 1'b1;
      end

      mode_in  = mode_v;
      len_in   = len_v;
      line_in  = line_v;
      col_in   = col_v;
      sline_in = sl_v;
      scol_in  = sc_v;
      res      = r_v;
      nres     = n_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         len_ff   <= '0;
         line_ff  <= POS_ONE;
         col_ff   <= POS_ONE;
         sline_ff <= POS_ONE;
         scol_ff  <= POS_ONE;
      end else if (accept) begin
         mode_ff  <= mode_in;
         len_ff   <= len_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         sline_ff <= sline_in;
         scol_ff  <= scol_in;
      end
   end

   // result queue
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         wptr_in = wptr_ff + QPTR_W'(nres);
         cnt_in  = cnt_in + (QPTR_W + 1)'(nres);
      end
      if (pop) begin
         rptr_in = rptr_ff + QPTR_W'(1);
         cnt_in  = cnt_in - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && nres != 2'd0) begin
         q_ff[wptr_ff] <= res[0];
      end
      if (accept && nres == 2'd2) begin
         q_ff[wptr_ff + QPTR_W'(1)] <= res[1];
      end
   end

   assign req.ready       = (cnt_ff <= (QPTR_W + 1)'(QDEPTH - 2));
   assign rsp.valid       = (cnt_ff != '0);
   assign rsp.event_res   = q_ff[rptr_ff].event_res;
   assign rsp.token_kind  = q_ff[rptr_ff].token_kind;
   assign rsp.text_byte   = q_ff[rptr_ff].text_byte;
   assign rsp.token_line  = q_ff[rptr_ff].token_line;
   assign rsp.token_col   = q_ff[rptr_ff].token_col;
   assign rsp.error_code  = q_ff[rptr_ff].error_code;
   assign rsp.last_in_run = q_ff[rptr_ff].last_in_run;

   // config port
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slimit_ff <= SLIMIT_W'(4095);
         ilimit_ff <= ILIMIT_W'(255);
         nlimit_ff <= NLIMIT_W'(63);
      end else if (csr_wr) begin
         case (csr_idx)
            REG_STRING_LIMIT: slimit_ff <= csr_pwdata[SLIMIT_W-1:0];
            REG_IDENT_LIMIT:  ilimit_ff <= csr_pwdata[ILIMIT_W-1:0];
            REG_NUMBER_LIMIT: nlimit_ff <= csr_pwdata[NLIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_STRING_LIMIT: csr_prdata = CSR_DATA_W'(slimit_ff);
         REG_IDENT_LIMIT:  csr_prdata = CSR_DATA_W'(ilimit_ff);
         REG_NUMBER_LIMIT: csr_prdata = CSR_DATA_W'(nlimit_ff);
         default:          csr_prdata = '0;
      endcase
   end

endmodule

@@ hw/rtl/qtt_checker.sv @@
// Port-level checker for the tokenizer and its bind
`include "query_text_tokenizer_core_assert.svh"

module qtt_checker
   import qtt_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_event_res,
   input logic [3:0] rsp_token_kind,
   input logic [2:0] rsp_error_code
);

   `QTT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   `QTT_ASSERT_NOW(a_err_beat, clock, reset, rsp_valid && rsp_event_res == EV_ERROR, rsp_token_kind == KIND_INVALID && rsp_error_code != ERR_NONE)

   `QTT_ASSERT_NOW(a_ok_beat, clock, reset, rsp_valid && rsp_event_res != EV_ERROR, rsp_error_code == ERR_NONE && rsp_token_kind != KIND_INVALID)

   `QTT_ASSERT_NOW(a_text_kind, clock, reset, rsp_valid && rsp_event_res == EV_TEXT, rsp_token_kind == KIND_STRING || rsp_token_kind == KIND_IDENT || rsp_token_kind == KIND_NUMBER)

endmodule

bind query_text_tokenizer_core qtt_checker u_qtt_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_event_res  (rsp.event_res),
   .rsp_token_kind (rsp.token_kind),
   .rsp_error_code (rsp.error_code)
);

@@ tb/sv/query_text_tokenizer_core_test.sv @@
// Testbench of query_text_tokenizer_core: directed table, then random sources checked by a lexer predictor
module query_text_tokenizer_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import qtt_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_ITEMS = 115;
   localparam logic [15:0] POS_MAX = '1;

   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_Q = 8'h71;

   typedef enum logic [2:0] {
      LX_IDLE, LX_COMMENT, LX_STRING, LX_ESCAPE, LX_IDENT, LX_NUMBER, LX_MINUS, LX_ERROR
   } lex_mode_type;

   // one source byte, optionally with its result typed in (typed: n results, at most one)
   typedef struct {
      logic [7:0] ch;
      bit         typed;
      int         n;
      rsp_type    tok;
   } src_row_type;

   localparam rsp_type NO_TOK = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qtt_req_if req_ch ();
   qtt_rsp_if rsp_ch ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   query_text_tokenizer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state and limits
   lex_mode_type lx_mode;
   int unsigned  txt_len;
   logic [15:0]  cur_line, cur_col, tok_line, tok_col;
   int unsigned  lim_str, lim_ident, lim_num;

   rsp_type     step_toks[$];
   rsp_type     tok_q[$];
   src_row_type hint_q[$];
   logic [7:0]  chunk[$];

   int err_count;
   int quiet_cycles;
   int rsp_hold;
   bit idle_on;

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      err_count++;
      $display("[%0t] mismatch %s: got %0d want %0d", $time, what, got, want);
   endtask

   function automatic rsp_type tk(logic [1:0] ev, logic [3:0] kind, int unsigned line,
                                  int unsigned col, logic [2:0] err);
      return '{ev, kind, 8'h00, 16'(line), 16'(col), err, 1'b1};
   endfunction

   function automatic src_row_type plain(logic [7:0] b);
      src_row_type r;
      r = '{b, 1'b0, 0, NO_TOK};
      return r;
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= CH_0 && c <= CH_0 + 8'd9;
   endfunction

   function automatic bit is_word(logic [7:0] c);
      return is_digit(c) || c == CH_UNDER || (c >= CH_LOW_A && c <= CH_LOW_A + 8'd25) ||
             (c >= CH_UP_A && c <= CH_UP_A + 8'd25);
   endfunction

   function automatic void emit_tok(logic [1:0] ev, logic [3:0] kind, logic [7:0] b,
                                    logic [15:0] line, logic [15:0] col, logic [2:0] err);
      rsp_type t;
      t = '{ev, kind, b, line, col, err, 1'b0};
      step_toks.push_back(t);
   endfunction

   function automatic void move_past(logic [7:0] c);
      if (c == CH_LF) begin
         if (cur_line != POS_MAX) cur_line++;
         cur_col = 16'd1;
      end else if (cur_col != POS_MAX) begin
         cur_col++;
      end
   endfunction

   function automatic void restart_source();
      lx_mode = LX_IDLE;
      txt_len = 0;
      cur_line = 16'd1;
      cur_col = 16'd1;
      tok_line = 16'd1;
      tok_col = 16'd1;
   endfunction

   function automatic void raise_fault(logic [2:0] err, logic [15:0] line, logic [15:0] col,
                                       logic [7:0] c);
      emit_tok(EV_ERROR, KIND_INVALID, 8'h00, line, col, err);
      if (c == CH_NUL) begin
         restart_source();
      end else begin
         lx_mode = LX_ERROR;
         txt_len = 0;
      end
   endfunction

   function automatic void emit_text(logic [3:0] kind, logic [7:0] b);
      txt_len++;
      emit_tok(EV_TEXT, kind, b, tok_line, tok_col, ERR_NONE);
   endfunction

   function automatic void lex_between(logic [7:0] c);
      logic [3:0] kind;
      kind = KIND_EOF;
      lx_mode = LX_IDLE;
      txt_len = 0;
      if (c == CH_NUL) begin
         emit_tok(EV_DONE, KIND_EOF, 8'h00, cur_line, cur_col, ERR_NONE);
         restart_source();
         return;
      end
      if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
         move_past(c);
         return;
      end
      if (c == CH_HASH) begin
         lx_mode = LX_COMMENT;
         move_past(c);
         return;
      end
      case (c)
         CH_LBRACE: kind = KIND_LBRACE;
         CH_RBRACE: kind = KIND_RBRACE;
         CH_LPAREN: kind = KIND_LPAREN;
         CH_RPAREN: kind = KIND_RPAREN;
         CH_COLON:  kind = KIND_COLON;
         CH_COMMA:  kind = KIND_COMMA;
         default:   kind = KIND_EOF;
      endcase
      if (kind != KIND_EOF) begin
         emit_tok(EV_DONE, kind, 8'h00, cur_line, cur_col, ERR_NONE);
         move_past(c);
         return;
      end
      tok_line = cur_line;
      tok_col = cur_col;
      if (c == CH_QUOTE) begin
         lx_mode = LX_STRING;
         move_past(c);
      end else if (c == CH_MINUS) begin
         lx_mode = LX_MINUS;
         move_past(c);
      end else if (is_word(c) && !is_digit(c)) begin
         if (lim_ident == 0) begin
            raise_fault(ERR_IDENT_LONG, cur_line, cur_col, c);
         end else begin
            lx_mode = LX_IDENT;
            emit_text(KIND_IDENT, c);
            move_past(c);
         end
      end else if (is_digit(c)) begin
         if (lim_num == 0) begin
            raise_fault(ERR_NUM_LONG, cur_line, cur_col, c);
         end else begin
            lx_mode = LX_NUMBER;
            emit_text(KIND_NUMBER, c);
            move_past(c);
         end
      end else begin
         raise_fault(ERR_UNEXPECTED, cur_line, cur_col, c);
      end
   endfunction

   // expected result beats of one source byte land in step_toks
   function automatic void lex_byte(logic [7:0] c);
      logic [7:0] d;
      step_toks.delete();
      case (lx_mode)
         LX_COMMENT: begin
            if (c == CH_NUL || c == CH_LF) lex_between(c);
            else move_past(c);
         end
         LX_STRING: begin
            if (c == CH_NUL) begin
               raise_fault(ERR_UNTERM, cur_line, cur_col, c);
            end else if (c == CH_QUOTE) begin
               emit_tok(EV_DONE, KIND_STRING, 8'h00, tok_line, tok_col, ERR_NONE);
               move_past(c);
               lx_mode = LX_IDLE;
               txt_len = 0;
            end else if (txt_len >= lim_str) begin
               raise_fault(ERR_STR_LONG, cur_line, cur_col, c);
            end else begin
               if (c == CH_BSLASH) lx_mode = LX_ESCAPE;
               else emit_text(KIND_STRING, c);
               move_past(c);
            end
         end
         LX_ESCAPE: begin
            case (c)
               CH_QUOTE:  d = CH_QUOTE;
               CH_BSLASH: d = CH_BSLASH;
               CH_LOW_N:  d = CH_LF;
               CH_LOW_T:  d = CH_TAB;
               default:   d = CH_NUL;
            endcase
            if (d == CH_NUL) begin
               if (c != CH_NUL) move_past(c);
               raise_fault(ERR_ESCAPE, cur_line, cur_col, c);
            end else begin
               emit_text(KIND_STRING, d);
               move_past(c);
               lx_mode = LX_STRING;
            end
         end
         LX_IDENT: begin
            if (is_word(c)) begin
               if (txt_len >= lim_ident) begin
                  raise_fault(ERR_IDENT_LONG, cur_line, cur_col, c);
               end else begin
                  emit_text(KIND_IDENT, c);
                  move_past(c);
               end
            end else begin
               emit_tok(EV_DONE, KIND_IDENT, 8'h00, tok_line, tok_col, ERR_NONE);
               lex_between(c);
            end
         end
         LX_NUMBER: begin
            if (is_digit(c) || c == CH_DOT || c == CH_MINUS) begin
               if (txt_len >= lim_num) begin
                  raise_fault(ERR_NUM_LONG, cur_line, cur_col, c);
               end else begin
                  emit_text(KIND_NUMBER, c);
                  move_past(c);
               end
            end else begin
               emit_tok(EV_DONE, KIND_NUMBER, 8'h00, tok_line, tok_col, ERR_NONE);
               lex_between(c);
            end
         end
         LX_MINUS: begin
            if (!is_digit(c)) begin
               raise_fault(ERR_UNEXPECTED, tok_line, tok_col, c);
            end else begin
               txt_len = 0;
               if (lim_num == 0) begin
                  raise_fault(ERR_NUM_LONG, tok_line, tok_col, c);
               end else begin
                  emit_text(KIND_NUMBER, CH_MINUS);
                  if (txt_len >= lim_num) begin
                     raise_fault(ERR_NUM_LONG, cur_line, cur_col, c);
                  end else begin
                     emit_text(KIND_NUMBER, c);
                     move_past(c);
                     lx_mode = LX_NUMBER;
                  end
               end
            end
         end
         LX_ERROR: begin
            if (c == CH_NUL) restart_source();
         end
         default: lex_between(c);
      endcase
      if (step_toks.size() > 0) step_toks[step_toks.size()-1].last_in_run = 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function automatic int pick_len(int unsigned lim);
      if (lim <= 8) return $urandom_range(0, lim + 2);
      if (lim <= 300 && $urandom_range(0, 4) == 0) return $urandom_range(lim - 1, lim + 1);
      return $urandom_range(1, 8);
   endfunction

   function automatic logic [7:0] word_char();
      int r;
      r = $urandom_range(0, 62);
      if (r < 26) return CH_LOW_A + 8'(r);
      if (r < 52) return CH_UP_A + 8'(r - 26);
      if (r < 62) return CH_0 + 8'(r - 52);
      return CH_UNDER;
   endfunction

   // mostly well-formed tokens with random content, some noise and broken ones
   function automatic void gen_chunk();
      int r, len;
      logic [7:0] b;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         case ($urandom_range(0, 5))
            0:       chunk.push_back(CH_LBRACE);
            1:       chunk.push_back(CH_RBRACE);
            2:       chunk.push_back(CH_LPAREN);
            3:       chunk.push_back(CH_RPAREN);
            4:       chunk.push_back(CH_COLON);
            default: chunk.push_back(CH_COMMA);
         endcase
      end else if (r < 22) begin
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 3))
               0:       chunk.push_back(CH_SPACE);
               1:       chunk.push_back(CH_TAB);
               2:       chunk.push_back(CH_LF);
               default: chunk.push_back(CH_CR);
            endcase
         end
      end else if (r < 28) begin
         chunk.push_back(CH_HASH);
         repeat ($urandom_range(0, 6)) chunk.push_back(8'($urandom_range(1, 255)));
         chunk.push_back($urandom_range(0, 4) == 0 ? CH_NUL : CH_LF);
      end else if (r < 48) begin
         chunk.push_back(CH_QUOTE);
         len = pick_len(lim_str);
         repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
               b = 8'($urandom_range(1, 255));
               if (b == CH_QUOTE || b == CH_BSLASH) b = CH_LOW_A;
               chunk.push_back(b);
            end else if (r < 96) begin
               chunk.push_back(CH_BSLASH);
               case ($urandom_range(0, 3))
                  0:       chunk.push_back(CH_QUOTE);
                  1:       chunk.push_back(CH_BSLASH);
                  2:       chunk.push_back(CH_LOW_N);
                  default: chunk.push_back(CH_LOW_T);
               endcase
            end else begin
               chunk.push_back(CH_BSLASH);
               chunk.push_back(8'($urandom_range(1, 255)));
            end
         end
         r = $urandom_range(0, 99);
         if (r < 88) chunk.push_back(CH_QUOTE);
         else if (r < 94) chunk.push_back(CH_NUL);
      end else if (r < 66) begin
         len = pick_len(lim_ident);
         if (len == 0) len = 1;
         b = word_char();
         if (is_digit(b)) b = CH_UNDER;
         chunk.push_back(b);
         repeat (len - 1) chunk.push_back(word_char());
      end else if (r < 82) begin
         if ($urandom_range(0, 3) == 0) chunk.push_back(CH_MINUS);
         len = pick_len(lim_num);
         if (len == 0) len = 1;
         chunk.push_back(CH_0 + 8'($urandom_range(0, 9)));
         repeat (len - 1) begin
            r = $urandom_range(0, 99);
            if (r < 80) chunk.push_back(CH_0 + 8'($urandom_range(0, 9)));
            else if (r < 90) chunk.push_back(CH_DOT);
            else chunk.push_back(CH_MINUS);
         end
      end else if (r < 87) begin
         chunk.push_back(CH_MINUS);
         chunk.push_back(8'($urandom_range(0, 255)));
      end else if (r < 96) begin
         chunk.push_back(8'($urandom_range(1, 255)));
      end else begin
         chunk.push_back(CH_NUL);
      end
   endfunction

   task automatic send_byte(src_row_type row);
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      hint_q.push_back(row);
      req_ch.valid <= 1'b1;
      req_ch.source_byte <= row.ch;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (tok_q.size() != 0 || hint_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_access(logic [1:0] idx, int unsigned value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== 32'(value)) report_mismatch("csr readback", csr_prdata, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_STRING_LIMIT: lim_str = value;
         REG_IDENT_LIMIT:  lim_ident = value;
         default:          lim_num = value;
      endcase
   endtask

   task automatic set_limits(int unsigned s, int unsigned i, int unsigned n);
      csr_access(REG_STRING_LIMIT, s);
      csr_access(REG_IDENT_LIMIT, i);
      csr_access(REG_NUMBER_LIMIT, n);
   endtask

   task automatic check_beat(rsp_type got);
      rsp_type want;
      if (tok_q.size() == 0) begin
         report_mismatch("beat with nothing expected, kind", got.token_kind, 0);
         return;
      end
      want = tok_q.pop_front();
      if (got.event_res !== want.event_res)
         report_mismatch("event_res", got.event_res, want.event_res);
      if (got.token_kind !== want.token_kind)
         report_mismatch("token_kind", got.token_kind, want.token_kind);
      if (got.text_byte !== want.text_byte)
         report_mismatch("text_byte", got.text_byte, want.text_byte);
      if (got.token_line !== want.token_line)
         report_mismatch("token_line", got.token_line, want.token_line);
      if (got.token_col !== want.token_col)
         report_mismatch("token_col", got.token_col, want.token_col);
      if (got.error_code !== want.error_code)
         report_mismatch("error_code", got.error_code, want.error_code);
      if (got.last_in_run !== want.last_in_run)
         report_mismatch("last_in_run", got.last_in_run, want.last_in_run);
   endtask

   always @(posedge clock) begin : beat_monitor
      src_row_type row;
      rsp_type     got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            row = hint_q.pop_front();
            lex_byte(req_ch.source_byte);
            if (row.typed) begin
               if (row.n > 0) tok_q.push_back(row.tok);
            end else begin
               foreach (step_toks[k]) tok_q.push_back(step_toks[k]);
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.event_res, rsp_ch.token_kind, rsp_ch.text_byte, rsp_ch.token_line,
                    rsp_ch.token_col, rsp_ch.error_code, rsp_ch.last_in_run};
            check_beat(got);
         end
      end
   end

   always @(posedge clock) begin : rsp_stall
      int g;
      if (rsp_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else begin
         g = pick_gap();
         rsp_ch.ready <= (g == 0);
         if (g > 0) rsp_hold <= g - 1;
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : main_flow
      src_row_type dir_rows[$];
      int p, sent;

      req_ch.valid = 1'b0;
      req_ch.source_byte = 8'h00;
      rsp_ch.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      err_count = 0;
      quiet_cycles = 0;
      rsp_hold = 0;
      idle_on = 1'b1;
      lim_str = 4095;
      lim_ident = 255;
      lim_num = 63;
      restart_source();

      // punctuation, whitespace, escapes, held minus, error mode, end of source
      dir_rows.push_back('{CH_LBRACE, 1'b1, 1, tk(EV_DONE, KIND_LBRACE, 1, 1, ERR_NONE)});
      dir_rows.push_back('{CH_RBRACE, 1'b1, 1, tk(EV_DONE, KIND_RBRACE, 1, 2, ERR_NONE)});
      dir_rows.push_back('{CH_LPAREN, 1'b1, 1, tk(EV_DONE, KIND_LPAREN, 1, 3, ERR_NONE)});
      dir_rows.push_back('{CH_RPAREN, 1'b1, 1, tk(EV_DONE, KIND_RPAREN, 1, 4, ERR_NONE)});
      dir_rows.push_back('{CH_COLON, 1'b1, 1, tk(EV_DONE, KIND_COLON, 1, 5, ERR_NONE)});
      dir_rows.push_back('{CH_COMMA, 1'b1, 1, tk(EV_DONE, KIND_COMMA, 1, 6, ERR_NONE)});
      dir_rows.push_back('{CH_TAB, 1'b1, 0, NO_TOK});
      dir_rows.push_back('{CH_LF, 1'b1, 0, NO_TOK});
      dir_rows.push_back(plain(CH_QUOTE));
      dir_rows.push_back(plain(CH_BSLASH));
      dir_rows.push_back(plain(CH_LOW_N));
      dir_rows.push_back(plain(CH_QUOTE));
      dir_rows.push_back(plain(CH_MINUS));
      dir_rows.push_back(plain(CH_0 + 8'd7));
      dir_rows.push_back(plain(CH_COMMA));
      dir_rows.push_back(plain(8'hff));
      dir_rows.push_back('{CH_NUL, 1'b1, 0, NO_TOK});
      dir_rows.push_back('{CH_NUL, 1'b1, 1, tk(EV_DONE, KIND_EOF, 1, 1, ERR_NONE)});
      dir_rows.push_back('{CH_QUOTE, 1'b1, 0, NO_TOK});
      dir_rows.push_back('{CH_BSLASH, 1'b1, 0, NO_TOK});
      dir_rows.push_back('{CH_LOW_Q, 1'b1, 1, tk(EV_ERROR, KIND_INVALID, 1, 4, ERR_ESCAPE)});
      dir_rows.push_back('{CH_NUL, 1'b1, 0, NO_TOK});
      dir_rows.push_back('{CH_MINUS, 1'b1, 0, NO_TOK});
      dir_rows.push_back('{CH_NUL, 1'b1, 1, tk(EV_ERROR, KIND_INVALID, 1, 1, ERR_UNEXPECTED)});

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k]) send_byte(dir_rows[k]);
      drain();

      for (p = 0; p < 6; p++) begin
         case (p)
            0: set_limits(1, 1, 1);
            1: set_limits(0, 0, 0);
            2: set_limits($urandom_range(2, 6), $urandom_range(2, 6), $urandom_range(2, 6));
            3: set_limits(4095, 255, 63);
            4: set_limits($urandom_range(1, 4095), $urandom_range(1, 255), $urandom_range(1, 63));
            default: set_limits(8, 12, 5);
         endcase
         idle_on = (p != 2);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            chunk.delete();
            gen_chunk();
            foreach (chunk[k]) send_byte(plain(chunk[k]));
            sent += chunk.size();
         end
         send_byte(plain(CH_NUL));
         drain();
      end

      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
